@@ rtl/sorted_cursor_list_queue_macros.svh @@
// Assertion macros for the sorted cursor list queue
`ifndef SORTED_CURSOR_LIST_QUEUE_MACROS_SVH
`define SORTED_CURSOR_LIST_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define SCLQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SCLQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCLQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SCLQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/sclq_pkg.sv @@
// ----------------------------------------------------------------------------
// sclq_pkg
// Types, constants and controller interface of the sorted cursor list queue.
// ----------------------------------------------------------------------------
package sclq_pkg;

    localparam int DEPTH  = 64;
    localparam int SLOT_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 7;
    localparam logic [SLOT_W-1:0] NIL_LINK = SLOT_W'(DEPTH);

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] key;
        logic [7:0]  payload;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      out_key;
        logic [7:0]       out_payload;
        logic [CNT_W-1:0] occupied;
    } t_rsp;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LATCH    = 4'd1;  // capture request, check refusal
    localparam logic [3:0] OP_RD_ENDS  = 4'd2;  // read key of tail into rd reg
    localparam logic [3:0] OP_CMP_TAIL = 4'd3;
    localparam logic [3:0] OP_RD_HEAD  = 4'd4;
    localparam logic [3:0] OP_CMP_HEAD = 4'd5;
    localparam logic [3:0] OP_RD_CUR   = 4'd6;  // read key/next/prev at cursor
    localparam logic [3:0] OP_CMP_CUR  = 4'd7;  // compare, advance or link
    localparam logic [3:0] OP_REMOVE   = 4'd8;  // read head record
    localparam logic [3:0] OP_UNLINK   = 4'd9;
    localparam logic [3:0] OP_RD_FREE  = 4'd10; // read next of free slot
    localparam logic [3:0] OP_INS_EMPTY= 4'd11;
    localparam logic [3:0] OP_INS_TAIL = 4'd12;
    localparam logic [3:0] OP_INS_HEAD = 4'd13;
    localparam logic [3:0] OP_FIN_INS  = 4'd14;
    localparam logic [3:0] OP_RD_PREV  = 4'd15; // link prev of cursor forward to new slot, new slot back (mid link)

    typedef struct packed {
        logic       go;
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic refuse;     // request refused, result ready
        logic is_remove;
        logic list_empty;
        logic ge_tail;
        logic le_head;
        logic cur_gt;     // cursor key above new key
        logic rsp_busy;   // output register holds an untaken beat
        logic clr_done;
    } t_sts;

endpackage

@@ rtl/sclq_datapath.sv @@
// ----------------------------------------------------------------------------
// sclq_datapath
// Slot stores, link memories, list pointers and the result register.
// ----------------------------------------------------------------------------
module sclq_datapath
    import sclq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_rsp_take,
    output t_sts             o_sts,
    output logic             o_rsp_valid,
    output t_rsp             o_rsp
);

    // memories: one write and one registered read per cycle each
    logic [15:0]       key_mem  [DEPTH];
    logic [7:0]        pay_mem  [DEPTH];
    logic [SLOT_W-1:0] next_mem [DEPTH];
    logic [SLOT_W-1:0] prev_mem [DEPTH];

    logic [CNT_W-1:0]  r_cap;
    logic [SLOT_W-1:0] r_head, r_tail, r_free, r_cur, r_new;
    logic [CNT_W-1:0]  r_cnt;
    t_req              r_req;
    logic [15:0]       r_rd_key;
    logic [7:0]        r_rd_pay;
    logic [SLOT_W-1:0] r_rd_next, r_rd_prev;
    logic              r_refuse;
    logic              r_vld;
    t_rsp              r_rsp;
    logic              r_clr;
    logic [IDX_W-1:0]  r_clr_idx;

    // memory port controls
    logic              key_we, nx_we, pv_we;
    logic [IDX_W-1:0]  key_wa, nx_wa, pv_wa, rd_a;
    logic [15:0]       key_wd;
    logic [SLOT_W-1:0] nx_wd, pv_wd;
    logic              rd_en;
    logic [CNT_W-1:0]  eff_cap;
    logic              full_now;
    logic              rsp_load;
    t_rsp              rsp_d;

    assign eff_cap  = (r_cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_cap;
    assign full_now = (r_cnt >= eff_cap) || (r_free == NIL_LINK);

    // port selection per operation
    always_comb begin
        key_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        key_wa = r_new[IDX_W-1:0]; nx_wa = r_new[IDX_W-1:0]; pv_wa = r_new[IDX_W-1:0];
        key_wd = r_req.key; nx_wd = NIL_LINK; pv_wd = NIL_LINK;
        rd_en  = 1'b0; rd_a = r_cur[IDX_W-1:0];
        rsp_load = 1'b0;
        rsp_d = '0;
        if (r_clr) begin
            nx_we = 1'b1; pv_we = 1'b1;
            nx_wa = r_clr_idx; pv_wa = r_clr_idx;
            nx_wd = SLOT_W'(r_clr_idx) + SLOT_W'(1);
        end else if (i_cmd.go) begin
            unique case (i_cmd.op)
                OP_RD_ENDS: begin
                    rd_en = 1'b1; rd_a = r_tail[IDX_W-1:0];
                end
                OP_RD_HEAD, OP_REMOVE: begin
                    rd_en = 1'b1; rd_a = r_head[IDX_W-1:0];
                end
                OP_RD_CUR: begin
                    rd_en = 1'b1; rd_a = r_cur[IDX_W-1:0];
                end
                OP_RD_FREE: begin
                    rd_en = 1'b1; rd_a = r_free[IDX_W-1:0];
                    key_we = 1'b1;
                end
                OP_CMP_TAIL: begin
                    // detach the new slot: both links null until it is placed
                    nx_we = 1'b1; pv_we = 1'b1;
                end
                OP_INS_EMPTY: begin
                    nx_we = 1'b1; pv_we = 1'b1;
                end
                OP_INS_TAIL: begin
                    nx_we = 1'b1; nx_wa = r_tail[IDX_W-1:0]; nx_wd = r_new;
                    pv_we = 1'b1; pv_wd = r_tail;
                end
                OP_INS_HEAD: begin
                    // new slot -> old head; old head prev -> new
                    nx_we = 1'b1; nx_wd = r_head;
                    pv_we = 1'b1; pv_wa = r_head[IDX_W-1:0]; pv_wd = r_new;
                end
                OP_CMP_CUR: begin
                    if (o_sts.cur_gt) begin
                        // new slot -> cursor; cursor prev -> new
                        pv_we = 1'b1; pv_wa = r_cur[IDX_W-1:0]; pv_wd = r_new;
                        nx_we = 1'b1; nx_wd = r_cur;
                    end
                end
                OP_RD_PREV: begin
                    // link predecessor forward to new, new back to it
                    nx_we = 1'b1; nx_wa = r_rd_prev[IDX_W-1:0]; nx_wd = r_new;
                    pv_we = 1'b1; pv_wd = r_rd_prev;
                end
                OP_UNLINK: begin
                    nx_we = 1'b1; nx_wa = r_head[IDX_W-1:0]; nx_wd = r_free;
                    pv_we = (r_rd_next != NIL_LINK);
                    pv_wa = r_rd_next[IDX_W-1:0]; pv_wd = NIL_LINK;
                    rsp_load = 1'b1;
                    rsp_d.status = ST_DONE; rsp_d.out_key = r_rd_key;
                    rsp_d.out_payload = r_rd_pay; rsp_d.occupied = r_cnt - CNT_W'(1);
                end
                OP_FIN_INS: begin
                    rsp_load = 1'b1;
                    rsp_d.status = ST_DONE; rsp_d.occupied = r_cnt + CNT_W'(1);
                end
                OP_LATCH: begin
                    if (i_req.req_type == REQ_REMOVE ? (r_cnt == '0) : full_now) begin
                        rsp_load = 1'b1;
                        rsp_d.status = (i_req.req_type == REQ_REMOVE) ? ST_EMPTY : ST_FULL;
                        rsp_d.occupied = r_cnt;
                    end
                end
                default: ;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_wa] <= key_wd;
            pay_mem[key_wa] <= r_req.payload;
        end
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        if (pv_we) prev_mem[pv_wa] <= pv_wd;
        if (rd_en) begin
            r_rd_key  <= key_mem[rd_a];
            r_rd_pay  <= pay_mem[rd_a];
            r_rd_next <= next_mem[rd_a];
            r_rd_prev <= prev_mem[rd_a];
        end
    end

    // pointers, count and request capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CNT_W'(64); r_head <= NIL_LINK; r_tail <= NIL_LINK;
            r_free <= '0; r_cnt <= '0; r_vld <= 1'b0; r_refuse <= 1'b0;
            r_clr <= 1'b1; r_clr_idx <= '0; r_cur <= NIL_LINK; r_new <= '0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(DEPTH - 1)) r_clr <= 1'b0;
            end
            if (i_rsp_take) r_vld <= 1'b0;
            if (rsp_load) begin
                r_vld <= 1'b1; r_rsp <= rsp_d;
            end
            if (i_cmd.go) begin
                unique case (i_cmd.op)
                    OP_LATCH: begin
                        r_req <= i_req;
                        r_refuse <= (i_req.req_type == REQ_REMOVE) ? (r_cnt == '0)
                                                                     : full_now;
                        r_new <= r_free;
                    end
                    OP_RD_FREE: ;
                    OP_RD_ENDS: ;
                    OP_CMP_TAIL: r_free <= r_rd_next;
                    OP_INS_EMPTY: begin
                        r_head <= r_new; r_tail <= r_new;
                    end
                    OP_INS_TAIL: r_tail <= r_new;
                    OP_INS_HEAD: r_head <= r_new;
                    OP_RD_HEAD: r_cur <= r_head;
                    OP_CMP_CUR: if (!o_sts.cur_gt) r_cur <= r_rd_next;
                    OP_FIN_INS: r_cnt <= r_cnt + CNT_W'(1);
                    OP_UNLINK: begin
                        r_free <= r_head;
                        r_head <= r_rd_next;
                        if (r_rd_next == NIL_LINK) r_tail <= NIL_LINK;
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_sts.refuse     = r_refuse;
    assign o_sts.is_remove  = r_req.req_type;
    assign o_sts.list_empty = (r_head == NIL_LINK);
    assign o_sts.ge_tail    = (r_req.key >= r_rd_key);
    assign o_sts.le_head    = (r_req.key <= r_rd_key);
    assign o_sts.cur_gt     = (r_req.key < r_rd_key);
    assign o_sts.rsp_busy   = r_vld && !i_rsp_take;
    assign o_sts.clr_done   = !r_clr;

    assign o_rsp_valid = r_vld;
    assign o_rsp       = r_rsp;

endmodule

@@ rtl/sclq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sclq_ctrl
// Sequencer for insert and remove-min: at most one datapath operation per step.
// ----------------------------------------------------------------------------
module sclq_ctrl
    import sclq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_sts i_sts,
    output logic o_req_stall,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_FREE   = 4'd2;
    localparam logic [3:0] S_ENDS   = 4'd3;
    localparam logic [3:0] S_CTAIL  = 4'd4;
    localparam logic [3:0] S_RHEAD  = 4'd5;
    localparam logic [3:0] S_CHEAD  = 4'd6;
    localparam logic [3:0] S_RCUR   = 4'd7;
    localparam logic [3:0] S_CCUR   = 4'd8;
    localparam logic [3:0] S_LPREV  = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_RREM   = 4'd11;
    localparam logic [3:0] S_UNLINK = 4'd12;
    localparam logic [3:0] S_HLINK  = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_empty_ins, n_empty_ins;

    // accept only when idle, clear pass done and no result waiting
    assign o_req_stall = !(r_state == S_IDLE && i_sts.clr_done && !i_sts.rsp_busy);

    always_comb begin
        n_state = r_state;
        n_empty_ins = r_empty_ins;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && !o_req_stall) begin
                    o_cmd = '{go: 1'b1, op: OP_LATCH};
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.refuse) n_state = S_IDLE;
                else if (i_sts.is_remove) n_state = S_RREM;
                else begin
                    n_empty_ins = i_sts.list_empty;
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                o_cmd = '{go: 1'b1, op: OP_RD_FREE};
                n_state = S_CTAIL;
            end
            S_CTAIL: begin
                // pops the free chain (read data holds next of free slot)
                o_cmd = '{go: 1'b1, op: OP_CMP_TAIL};
                n_state = r_empty_ins ? S_HLINK : S_ENDS;
            end
            S_ENDS: begin
                o_cmd = '{go: 1'b1, op: OP_RD_ENDS};
                n_state = S_RHEAD;
            end
            S_RHEAD: begin
                if (i_sts.ge_tail) begin
                    o_cmd = '{go: 1'b1, op: OP_INS_TAIL};
                    n_state = S_FIN;
                end else begin
                    o_cmd = '{go: 1'b1, op: OP_RD_HEAD};
                    n_state = S_CHEAD;
                end
            end
            S_CHEAD: begin
                if (i_sts.le_head) begin
                    o_cmd = '{go: 1'b1, op: OP_INS_HEAD};
                    n_state = S_FIN;
                end else begin
                    o_cmd = '{go: 1'b1, op: OP_CMP_CUR};
                    n_state = S_RCUR;
                end
            end
            S_HLINK: begin
                // empty list: new slot becomes head and tail
                o_cmd = '{go: 1'b1, op: OP_INS_EMPTY};
                n_state = S_FIN;
            end
            S_RCUR: begin
                o_cmd = '{go: 1'b1, op: OP_RD_CUR};
                n_state = S_CCUR;
            end
            S_CCUR: begin
                o_cmd = '{go: 1'b1, op: OP_CMP_CUR};
                n_state = i_sts.cur_gt ? S_LPREV : S_RCUR;
            end
            S_LPREV: begin
                o_cmd = '{go: 1'b1, op: OP_RD_PREV};
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd = '{go: 1'b1, op: OP_FIN_INS};
                n_state = S_IDLE;
            end
            S_RREM: begin
                o_cmd = '{go: 1'b1, op: OP_REMOVE};
                n_state = S_UNLINK;
            end
            S_UNLINK: begin
                o_cmd = '{go: 1'b1, op: OP_UNLINK};
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_empty_ins <= 1'b0;
        end else begin
            r_state <= n_state;
            r_empty_ins <= n_empty_ins;
        end
    end

endmodule

@@ rtl/sorted_cursor_list_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_cursor_list_queue
// Priority queue over a sorted doubly linked list of 64 slots with free chain.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass over all 64 slots
// rebuilds the link memories before the first request is taken. A remove-min
// reads the head record, then unlinks it; a tail or head insert reads the
// ends after taking a free slot, and a middle insert walks the list from the
// head, one link memory read and then the compare per slot. A request is
// taken only once the previous result beat has left the output register.
module sorted_cursor_list_queue
    import sclq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output t_rsp             o_rsp
);
`include "sorted_cursor_list_queue_macros.svh"

    t_cmd cmd;
    t_sts sts;

    sclq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_sts       (sts),
        .o_req_stall (o_req_stall),
        .o_cmd       (cmd)
    );

    sclq_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rsp_take  (o_rsp_valid && !i_rsp_stall),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

    `SCLQ_ASSERT_IMP(a_occ_range, i_clk, i_rst_n, o_rsp_valid, o_rsp.occupied <= CNT_W'(DEPTH), "occupied above depth")
    `SCLQ_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_rsp_valid, o_rsp.status <= ST_EMPTY, "bad status code")
    `SCLQ_ASSERT_NXT(a_one_req, i_clk, i_rst_n, i_req_valid && !o_req_stall, o_req_stall, "request taken while busy")

endmodule

@@ test/sorted_cursor_list_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_cursor_list_queue_tb
// Drives inserts and remove-min requests into the sorted list queue under
// random valid and stall gaps and several capacity settings. A scoreboard
// keeps its own sorted copy of the queue and checks every result beat.
// ----------------------------------------------------------------------------
module sorted_cursor_list_queue_tb;
    import sclq_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;

    // Sorted queue model and store of expected result beats
    class queue_scoreboard;
        t_req entries[$];
        int   cap_limit;
        t_rsp pending[$];
        int   mismatches;

        function void set_capacity(int value);
            cap_limit = value;
        endfunction

        function void note_request(t_req req);
            t_rsp rsp;
            int   pos;
            int   eff;
            rsp = '0;
            eff = (cap_limit > DEPTH) ? DEPTH : cap_limit;
            if (req.req_type == REQ_INSERT) begin
                if (entries.size() >= eff) begin
                    rsp.status = ST_FULL;
                end else begin
                    // after keys <= it, but first if key <= head < tail
                    pos = entries.size();
                    for (int i = 0; i < entries.size(); i++) begin
                        if (entries[i].key > req.key) begin
                            pos = i;
                            break;
                        end
                    end
                    if (entries.size() > 0 && req.key <= entries[0].key
                            && req.key < entries[$].key) begin
                        pos = 0;
                    end
                    entries.insert(pos, req);
                    rsp.status = ST_DONE;
                end
            end else begin
                if (entries.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.status      = ST_DONE;
                    rsp.out_key     = entries[0].key;
                    rsp.out_payload = entries[0].payload;
                    void'(entries.pop_front());
                end
            end
            rsp.occupied = CNT_W'(entries.size());
            pending.push_back(rsp);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.out_key !== want.out_key ||
                    got.out_payload !== want.out_payload ||
                    got.occupied !== want.occupied) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;
    logic             i_req_valid = 1'b0;
    logic             o_req_stall;
    t_req             i_req = '0;
    logic             o_rsp_valid;
    logic             i_rsp_stall = 1'b0;
    t_rsp             o_rsp;

    queue_scoreboard board;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;
    longint cycle_count = 0;

    sorted_cursor_list_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always #2 i_clk = ~i_clk;

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stall, long hold-off on request, check each beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall)
            board.check_result(o_rsp);
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Send one request beat, idling at random first; valid stays up after
    // the accept until the next beat or stop_sending drives it
    task automatic send_request(input t_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (o_req_stall);
        board.note_request(req);
    endtask

    // Drop valid when the request stream pauses
    task automatic stop_sending();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_op(input logic kind, input int key, input int pay);
        t_req req;
        req.req_type = kind;
        req.key = 16'(key);
        req.payload = 8'(pay);
        send_request(req);
    endtask

    // Wait for all results, then write capacity while idle
    task automatic write_capacity(input int value);
        stop_sending();
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= CNT_W'(value);
        board.set_capacity(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random phase: bursts of inserts and removes with random keys
    task automatic random_phase(input int count);
        int k;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: k = $urandom_range(65535);
                1: k = $urandom_range(15);
                2: k = 65520 + $urandom_range(15);
                default: k = $urandom_range(300);
            endcase
            if ($urandom_range(99) < ((n / 40) % 2 ? 35 : 60))
                send_op(REQ_INSERT, k, $urandom_range(255));
            else
                send_op(REQ_REMOVE, $urandom_range(65535), $urandom_range(255));
        end
    endtask

    initial begin
        board = new();
        board.set_capacity(64);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty remove, extremes, head, tail, middle, equal keys
        send_op(REQ_REMOVE, 0, 0);
        send_op(REQ_INSERT, 1000, 8'hFF);
        send_op(REQ_INSERT, 65535, 0);
        send_op(REQ_INSERT, 0, 8'hA5);
        send_op(REQ_INSERT, 1000, 1);
        send_op(REQ_INSERT, 500, 2);
        send_op(REQ_INSERT, 0, 3);
        send_op(REQ_INSERT, 65535, 4);
        send_op(REQ_INSERT, 16'h5555, 8'h5A);
        send_op(REQ_INSERT, 16'hAAAA, 8'h55);
        for (int i = 0; i < 10; i++)
            send_op(REQ_REMOVE, 16'hFFFF, 8'hFF);

        // Capacity of one, then zero, then 127 (above depth)
        write_capacity(1);
        send_op(REQ_INSERT, 7, 7);
        send_op(REQ_INSERT, 8, 8);
        write_capacity(0);
        send_op(REQ_INSERT, 9, 9);
        send_op(REQ_REMOVE, 0, 0);
        write_capacity(127);

        send_idle_pct = 31;
        recv_idle_pct = 74;
        random_phase(400);

        // Fill the store with the receiver held off, then lower capacity
        hold_off_cycles = 3000;
        for (int i = 0; i < 70; i++)
            send_op(REQ_INSERT, $urandom_range(65535), $urandom_range(255));
        write_capacity(5);
        send_op(REQ_INSERT, 1, 1);
        write_capacity(3);
        send_idle_pct = 74;
        recv_idle_pct = 31;
        random_phase(400);
        write_capacity(64);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(400);

        stop_sending();
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
